### hdl/stc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and the CORDIC angle table for the sphere texture
// coordinate pipeline.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int ANGLE_STEPS = 18;
    localparam int FRAC_BITS   = 16;

    localparam int CRD_W     = 47;   // CORDIC datapath width, signed
    localparam int DIFF_W    = 33;   // exact center difference
    localparam int SHIFT_W   = 6;    // normalize shift amount
    localparam int NORM_TOP  = 40;
    localparam int GAIN_W    = 20;
    localparam int MUL_SPLIT = 22;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q20 = 20'd636751;
    localparam logic [31:0]       HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0]       THREE_QTR    = 32'hC000_0000;

    localparam int STEP_W = 5;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2
    } stc_reg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [DIFF_W-1:0]        m;
        logic [SHIFT_W-1:0]       k;
        logic signed [CRD_W-1:0]  x;
        logic signed [CRD_W-1:0]  y;
        logic signed [CRD_W-1:0]  z;
        logic [31:0]              acc;
        logic [31:0]              azim;
        logic                     axis;
        logic                     at_center;
        logic [15:0]              tex_s;
        logic [16:0]              tex_t;
    } stc_stage_t;

    // atan(2^-i) in turns * 2^32
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680094;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // position of the highest set bit
    function automatic logic [SHIFT_W-1:0] msb_pos(input logic [DIFF_W-1:0] v);
        logic [SHIFT_W-1:0] p;
        p = '0;
        for (int b = 0; b < DIFF_W; b++) begin
            if (v[b])
                p = SHIFT_W'(b);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

### hdl/stc_cordic_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_cordic_step
// One vectoring CORDIC micro-rotation: drives y toward zero and accumulates
// the angle. Shifts are arithmetic (floor).
// ----------------------------------------------------------------------------
module stc_cordic_step (
    input  var stc_pkg::stc_stage_t        in_stage,
    input  var logic [stc_pkg::STEP_W-1:0] shift_amt,
    input  var logic [31:0]                angle,
    output stc_pkg::stc_stage_t            out_stage
);
    import stc_pkg::*;

    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;

    assign xs = in_stage.x >>> shift_amt;
    assign ys = in_stage.y >>> shift_amt;

    always_comb
    begin
        out_stage = in_stage;
        if (in_stage.y[CRD_W-1])
        begin
            out_stage.x   = in_stage.x - ys;
            out_stage.y   = in_stage.y + xs;
            out_stage.acc = in_stage.acc - angle;
        end
        else
        begin
            out_stage.x   = in_stage.x + ys;
            out_stage.y   = in_stage.y - xs;
            out_stage.acc = in_stage.acc + angle;
        end
    end

endmodule
`default_nettype wire

### hdl/sphere_texture_coordinates.sv
`default_nettype none
// Throughput: one word per cycle while the output is not stalled; every CORDIC iteration is its own stage.
// Each stage holds its word while the next is full, so bubbles collapse.
// Reset clears all valid bits and the center registers to zero.
// ----------------------------------------------------------------------------
// sphere_texture_coordinates
// Spherical (s, t) texture coordinates of a vertex around a configured center.
// ----------------------------------------------------------------------------
module sphere_texture_coordinates (
    input  var logic        clk,
    input  var logic        rst_n,
    input  var logic        cfg_we,
    input  var logic [1:0]  cfg_index,
    input  var logic [31:0] cfg_data,
    input  var logic        s_tvalid,
    output logic            s_tready,
    input  var logic [95:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic            m_tvalid,
    input  var logic        m_tready,
    output logic [39:0]     m_tdata,   // tex_s, tex_t, zero pad
    output logic            m_tuser    // at_center
);
    import stc_pkg::*;

    localparam int C1_PRE  = 4;
    localparam int C1_END  = C1_PRE + ANGLE_STEPS;
    localparam int MUL_A   = C1_END + 1;
    localparam int MUL_B   = C1_END + 2;
    localparam int C2_PRE  = C1_END + 3;
    localparam int C2_END  = C2_PRE + ANGLE_STEPS;
    localparam int OUT_STG = C2_END + 1;
    localparam int NSTG    = OUT_STG + 1;
    localparam int PROD_W  = CRD_W + GAIN_W + 1;
    localparam int LO_W    = MUL_SPLIT + GAIN_W;
    localparam int HI_W    = CRD_W - MUL_SPLIT + GAIN_W;

    localparam logic [15:0] S_MASK = (FRAC_BITS >= 16) ? 16'hFFFF
                                   : 16'((33'(1) << FRAC_BITS) - 33'(1));
    localparam logic [16:0] T_MASK = (FRAC_BITS >= 16) ? 17'h1FFFF
                                   : 17'((33'(1) << (FRAC_BITS + 1)) - 33'(1));

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    stc_stage_t pipe_reg  [NSTG];
    stc_stage_t pipe_next [NSTG];
    logic       valid_reg [NSTG];
    logic       rdy       [NSTG+1];

    assign rdy[NSTG] = m_tready;
    assign s_tready  = rdy[0];

    genvar g;
    generate
        for (g = 0; g < NSTG; g++)
        begin : g_stage
            assign rdy[g] = !valid_reg[g] || rdy[g+1];

            if (g == 0)
            begin : g_diff
                logic signed [31:0] vx;
                logic signed [31:0] vy;
                logic signed [31:0] vz;
                assign vx = s_tdata[31:0];
                assign vy = s_tdata[63:32];
                assign vz = s_tdata[95:64];
                always_comb
                begin
                    pipe_next[g] = '0;
                    pipe_next[g].dx = DIFF_W'(vx) - DIFF_W'(center_x_reg);
                    pipe_next[g].dy = DIFF_W'(vy) - DIFF_W'(center_y_reg);
                    pipe_next[g].dz = DIFF_W'(vz) - DIFF_W'(center_z_reg);
                    pipe_next[g].at_center = (vx == center_x_reg)
                                          && (vy == center_y_reg)
                                          && (vz == center_z_reg);
                end
            end
            else if (g == 1)
            begin : g_mag
                stc_stage_t p;
                assign p = pipe_reg[g-1];
                always_comb
                begin
                    pipe_next[g] = p;
                    pipe_next[g].m = (p.dx[DIFF_W-1] ? -p.dx : p.dx)
                                   | (p.dy[DIFF_W-1] ? -p.dy : p.dy)
                                   | (p.dz[DIFF_W-1] ? -p.dz : p.dz);
                    pipe_next[g].axis = (p.dx == '0) && (p.dy == '0);
                end
            end
            else if (g == 2)
            begin : g_lzc
                stc_stage_t p;
                assign p = pipe_reg[g-1];
                always_comb
                begin
                    pipe_next[g] = p;
                    pipe_next[g].k = SHIFT_W'(NORM_TOP) - msb_pos(p.m);
                end
            end
            else if (g == 3)
            begin : g_norm
                stc_stage_t p;
                assign p = pipe_reg[g-1];
                always_comb
                begin
                    pipe_next[g] = p;
                    pipe_next[g].x = CRD_W'(p.dx) <<< p.k;
                    pipe_next[g].y = CRD_W'(p.dy) <<< p.k;
                    pipe_next[g].z = CRD_W'(p.dz) <<< p.k;
                end
            end
            else if (g == C1_PRE || g == C2_PRE)
            begin : g_pre
                stc_stage_t p;
                assign p = pipe_reg[g-1];
                always_comb
                begin
                    pipe_next[g] = p;
                    pipe_next[g].acc = '0;
                    if (p.x[CRD_W-1])
                    begin
                        pipe_next[g].x   = -p.x;
                        pipe_next[g].y   = -p.y;
                        pipe_next[g].acc = HALF_TURN;
                    end
                end
            end
            else if ((g > C1_PRE && g <= C1_END) || (g > C2_PRE && g <= C2_END))
            begin : g_rot
                localparam int STEP = (g > C2_PRE) ? g - C2_PRE - 1 : g - C1_PRE - 1;
                stc_cordic_step u_step (
                    .in_stage  (pipe_reg[g-1]),
                    .shift_amt (STEP_W'(STEP)),
                    .angle     (atan_turn(STEP_W'(STEP))),
                    .out_stage (pipe_next[g])
                );
            end
            else if (g == MUL_A)
            begin : g_mul_a
                stc_stage_t p;
                logic [LO_W-1:0] lo_prod;
                logic [HI_W-1:0] hi_prod;
                assign p = pipe_reg[g-1];
                assign lo_prod = p.x[MUL_SPLIT-1:0] * INV_GAIN_Q20;
                assign hi_prod = p.x[CRD_W-1:MUL_SPLIT] * INV_GAIN_Q20;
                always_comb
                begin
                    pipe_next[g] = p;
                    pipe_next[g].azim = p.acc;
                    pipe_next[g].x = CRD_W'(lo_prod);
                    pipe_next[g].y = CRD_W'(hi_prod);
                end
            end
            else if (g == MUL_B)
            begin : g_mul_b
                stc_stage_t p;
                logic [PROD_W-1:0] prod;
                assign p = pipe_reg[g-1];
                assign prod = (PROD_W'(unsigned'(p.y)) << MUL_SPLIT)
                            + PROD_W'(unsigned'(p.x));
                always_comb
                begin
                    pipe_next[g] = p;
                    pipe_next[g].x = -p.z;
                    pipe_next[g].y = p.axis ? '0 : CRD_W'(prod >> GAIN_W);
                end
            end
            else
            begin : g_out
                stc_stage_t p;
                logic [31:0] b;
                logic [32:0] s_sum;
                logic [32:0] t_sum;
                logic [32:0] s_full;
                logic [32:0] t_full;
                assign p = pipe_reg[g-1];
                always_comb
                begin
                    if (p.acc >= THREE_QTR)
                        b = '0;
                    else if (p.acc > HALF_TURN)
                        b = HALF_TURN;
                    else
                        b = p.acc;
                    s_sum  = {1'b0, p.azim} + (33'(1) << (31 - FRAC_BITS));
                    t_sum  = {1'b0, b} + (33'(1) << (30 - FRAC_BITS));
                    s_full = s_sum >> (32 - FRAC_BITS);
                    t_full = t_sum >> (31 - FRAC_BITS);
                    pipe_next[g] = p;
                    pipe_next[g].tex_s = (p.axis || p.at_center) ? '0
                                       : (s_full[15:0] & S_MASK);
                    pipe_next[g].tex_t = p.at_center ? '0 : (t_full[16:0] & T_MASK);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (rdy[g])
                    valid_reg[g] <= (g == 0) ? s_tvalid : valid_reg[(g == 0) ? 0 : g-1];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[g])
                    pipe_reg[g] <= pipe_next[g];
            end
        end
    endgenerate

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {7'b0, pipe_reg[NSTG-1].tex_t, pipe_reg[NSTG-1].tex_s};
    assign m_tuser  = pipe_reg[NSTG-1].at_center;

`ifndef ASSERT_OFF
    a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[32:0] == '0)
        else $error("center word carries nonzero coordinates");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:16] <= (17'(1) << FRAC_BITS))
        else $error("tex_t above one");

    a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !pipe_reg[1].at_center |-> pipe_reg[1].m != '0)
        else $error("off-center vertex with zero magnitude");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !rdy[1] |=> valid_reg[1] && $stable(pipe_reg[1].m))
        else $error("stalled stage lost its word");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sphere_texture_coordinates: vertices stream in
// under random and forced stalls, each accepted word is run through a local
// CORDIC model, and every output word is compared against the oldest
// predicted texture coordinate.
// ----------------------------------------------------------------------------
module tb;
    import stc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 5000;

    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680094, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic [15:0] tex_s;
        logic [16:0] tex_t;
        logic        at_center;
    } texcoord_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_CENTER_X;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // vertex_x, vertex_y, vertex_z
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;        // tex_s, tex_t, zero pad
    logic        m_tuser;        // at_center

    logic [95:0] vertex_q [$];
    texcoord_t   coord_q [$];
    longint      ctr_x = 0, ctr_y = 0, ctr_z = 0;
    int          send_idle = 0, recv_idle = 0;
    int          hold_cycles = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    sphere_texture_coordinates DUT (.*);

    always #1 clk = ~clk;

    function automatic void cordic_vec(input longint xi, input longint yi,
                                       output logic [31:0] ang, output longint mag);
        longint x, y, xs, ys;
        x = xi;
        y = yi;
        ang = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = HALF_TURN;
        end
        for (int i = 0; i < ANGLE_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                ang = ang - ATAN_TAB[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                ang = ang + ATAN_TAB[i];
            end
        end
        mag = x;
    endfunction

    function automatic texcoord_t sphere_coord(input logic [95:0] v);
        texcoord_t r;
        longint dx, dy, dz, m, rho, g;
        logic [31:0] a, b;
        logic [63:0] tmp;
        int k;
        dx = longint'($signed(v[31:0])) - ctr_x;
        dy = longint'($signed(v[63:32])) - ctr_y;
        dz = longint'($signed(v[95:64])) - ctr_z;
        r = '0;
        if (dx == 0 && dy == 0 && dz == 0)
        begin
            r.at_center = 1'b1;
            return r;
        end
        m = (dx < 0 ? -dx : dx) | (dy < 0 ? -dy : dy) | (dz < 0 ? -dz : dz);
        k = 0;
        while (m < (longint'(1) << NORM_TOP) && k < 63)
        begin
            m = m << 1;
            k++;
        end
        dx = dx * (longint'(1) << k);
        dy = dy * (longint'(1) << k);
        dz = dz * (longint'(1) << k);
        rho = 0;
        if (dx != 0 || dy != 0)
        begin
            cordic_vec(dx, dy, a, g);
            tmp = (64'(a) + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
            r.tex_s = tmp[15:0];
            tmp = (64'(g) * 64'd636751) >> 20;
            rho = longint'(tmp);
        end
        cordic_vec(-dz, rho, b, g);
        if (b >= THREE_QTR)
            b = '0;
        else if (b > HALF_TURN)
            b = HALF_TURN;
        tmp = (64'(b) + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
        r.tex_t = tmp[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                coord_q.push_back(sphere_coord(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= vertex_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (coord_q.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    texcoord_t e;
                    e = coord_q.pop_front();
                    if (m_tdata[15:0] !== e.tex_s)
                        report_mismatch("tex_s", m_tdata[15:0], e.tex_s);
                    if (m_tdata[32:16] !== e.tex_t)
                        report_mismatch("tex_t", m_tdata[32:16], e.tex_t);
                    if (m_tuser !== e.at_center)
                        report_mismatch("at_center", m_tuser, e.at_center);
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_CENTER_X: ctr_x = longint'($signed(val));
            REG_CENTER_Y: ctr_y = longint'($signed(val));
            REG_CENTER_Z: ctr_z = longint'($signed(val));
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (vertex_q.size() > 0 || s_tvalid || coord_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(input longint c);
        case ($urandom_range(7))
            0, 1, 2: return $urandom;
            3, 4: return 32'(c + longint'($urandom_range(65535)) - 32768);
            5: return 32'(c);
            6: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(c + longint'($urandom_range(3)) - 1);
        endcase
    endfunction

    function automatic logic [95:0] vtx(input longint x, input longint y, input longint z);
        return {32'(z), 32'(y), 32'(x)};
    endfunction

    initial
    begin
        logic [31:0] cx, cy, cz;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, center at origin
        send_idle = 33;
        recv_idle = 81;
        vertex_q.push_back(vtx(0, 0, 0));
        vertex_q.push_back(vtx(0, 0, 65536));
        vertex_q.push_back(vtx(0, 0, -65536));
        vertex_q.push_back(vtx(1, 0, 0));
        vertex_q.push_back(vtx(-1, 0, 0));
        vertex_q.push_back(vtx(0, 1, 0));
        vertex_q.push_back(vtx(0, -1, 0));
        vertex_q.push_back(vtx(-65536, -1, 0));
        vertex_q.push_back(vtx(-65536, 1, 0));
        vertex_q.push_back(vtx(1, 1, 1));
        vertex_q.push_back(vtx(-1, -1, -1));
        vertex_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        vertex_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        vertex_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        vertex_q.push_back({32'h0, 32'h0, 32'h8000_0000});
        vertex_q.push_back({32'h0, 32'h8000_0000, 32'h0});
        drain();

        // extreme centers
        write_reg(REG_CENTER_X, 32'h8000_0000);
        write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Z, 32'h8000_0000);
        write_reg(REG_UNUSED, 32'h1234_5678);
        vertex_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        vertex_q.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        vertex_q.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        vertex_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 33 : (ph < 4) ? 81 : 0;
            recv_idle = (ph < 2) ? 81 : (ph < 4) ? 33 : 0;
            case (ph)
                0: begin cx = 32'h7FFF_FFFF; cy = 32'h8000_0000; cz = 32'h7FFF_FFFF; end
                1: begin cx = 0; cy = 0; cz = 0; end
                default: begin cx = $urandom; cy = $urandom; cz = $urandom; end
            endcase
            write_reg(REG_CENTER_X, cx);
            write_reg(REG_CENTER_Y, cy);
            write_reg(REG_CENTER_Z, cz);
            if (ph == 3)
                write_reg(REG_UNUSED, $urandom);
            for (int n = 0; n < 135; n++)
                vertex_q.push_back({pick_coord(ctr_z), pick_coord(ctr_y), pick_coord(ctr_x)});
            if (ph == 4)
                hold_cycles = 400;
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### sphere_texture_coordinates.f
hdl/stc_pkg.sv
hdl/stc_cordic_step.sv
hdl/sphere_texture_coordinates.sv
tb/tb.sv
